// ----- design/rmq_pkg.sv -----
`timescale 1ns / 1ps

package rmq_pkg;

	localparam int NUM_LANES = 4;
	localparam int ELEM_W    = 16;
	localparam int QW_W      = 15;
	localparam int IN_DATA_W = 144;
	localparam int OUT_DATA_W = 64;

	// lane order through the root pipe
	localparam int LANE_W = 0;
	localparam int LANE_X = 1;
	localparam int LANE_Y = 2;
	localparam int LANE_Z = 3;

	localparam logic [QW_W-1:0] MAG_MAX = 15'h7FFF;

	// right_x in the lowest bits, at_z in the highest
	typedef struct packed {
		logic signed [ELEM_W-1:0] at_z;
		logic signed [ELEM_W-1:0] at_y;
		logic signed [ELEM_W-1:0] at_x;
		logic signed [ELEM_W-1:0] up_z;
		logic signed [ELEM_W-1:0] up_y;
		logic signed [ELEM_W-1:0] up_x;
		logic signed [ELEM_W-1:0] right_z;
		logic signed [ELEM_W-1:0] right_y;
		logic signed [ELEM_W-1:0] right_x;
	} matrix_t;

	typedef struct packed {
		logic neg_z;
		logic neg_y;
		logic neg_x;
	} sign_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] q_z;
		logic signed [ELEM_W-1:0] q_y;
		logic signed [ELEM_W-1:0] q_x;
		logic [QW_W-1:0]          q_w;
	} result_t;

endpackage

// ----- design/rmq_front.sv -----
`timescale 1ns / 1ps

module rmq_front import rmq_pkg::*; #(
	parameter int FRACTION_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  matrix_t             in_m,
	output logic                out_valid,
	output logic [((FRACTION_BITS > 17) ? FRACTION_BITS : 17) + FRACTION_BITS:0]
	                            out_rad [NUM_LANES],
	output sign_t               out_sign
);

	localparam int SUM_W = ((FRACTION_BITS > 17) ? FRACTION_BITS : 17) + 2;
	localparam int MAG_W = SUM_W - 1;
	localparam int RW    = MAG_W + FRACTION_BITS;
	localparam logic signed [SUM_W-1:0] ONE =
		{{(SUM_W-1){1'b0}}, 1'b1} << FRACTION_BITS;

	logic signed [SUM_W-1:0] rx, uy, az;
	logic signed [SUM_W-1:0] sum [NUM_LANES];
	logic signed [ELEM_W:0]  dx, dy, dz;
	logic [RW-1:0]           rad [NUM_LANES];

	logic                    vld_s1;
	logic [RW-1:0]           rad_s1 [NUM_LANES];
	sign_t                   sign_s1;

	always_comb begin
		rx = SUM_W'(in_m.right_x);
		uy = SUM_W'(in_m.up_y);
		az = SUM_W'(in_m.at_z);
		sum[LANE_W] = ONE + rx + uy + az;
		sum[LANE_X] = ONE + rx - uy - az;
		sum[LANE_Y] = ONE - rx + uy - az;
		sum[LANE_Z] = ONE - rx - uy + az;
		for (int l = 0; l < NUM_LANES; l++) begin
			// clamp at zero, then scale so the root lands in the same format
			if (sum[l][SUM_W-1] || (sum[l] == '0)) begin
				rad[l] = '0;
			end else begin
				rad[l] = {sum[l][MAG_W-1:0], {FRACTION_BITS{1'b0}}};
			end
		end
		dx = (ELEM_W+1)'(in_m.at_y) - (ELEM_W+1)'(in_m.up_z);
		dy = (ELEM_W+1)'(in_m.right_z) - (ELEM_W+1)'(in_m.at_x);
		dz = (ELEM_W+1)'(in_m.up_x) - (ELEM_W+1)'(in_m.right_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1        <= rad;
			sign_s1.neg_x <= dx[ELEM_W];
			sign_s1.neg_y <= dy[ELEM_W];
			sign_s1.neg_z <= dz[ELEM_W];
		end
	end

	assign out_valid = vld_s1;
	assign out_rad   = rad_s1;
	assign out_sign  = sign_s1;

endmodule

// ----- design/rmq_root_pipe.sv -----
`timescale 1ns / 1ps

module rmq_root_pipe import rmq_pkg::*; #(
	parameter int RW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [RW-1:0]          in_rad [NUM_LANES],
	input  sign_t                  in_sign,
	output logic                   out_valid,
	output logic [(RW+1)/2-1:0]    out_root [NUM_LANES],
	output sign_t                  out_sign
);

	localparam int N  = (RW + 1) / 2;
	localparam int XW = 2 * N;

	// index k holds the word leaving digit step k - 1
	logic [XW-1:0] rem_s [1:N][NUM_LANES];
	logic [XW-1:0] res_s [1:N][NUM_LANES];
	logic          vld_s [1:N];
	sign_t         sgn_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [XW-1:0] BIT = {{(XW-1){1'b0}}, 1'b1} << (2 * (N - 1 - k));

		logic [XW-1:0] rem_in   [NUM_LANES];
		logic [XW-1:0] res_in   [NUM_LANES];
		logic          vld_in;
		sign_t         sgn_in;
		logic [XW-1:0] trial    [NUM_LANES];
		logic [XW-1:0] rem_next [NUM_LANES];
		logic [XW-1:0] res_next [NUM_LANES];

		if (k == 0) begin : g_src
			always_comb begin
				for (int l = 0; l < NUM_LANES; l++) begin
					rem_in[l] = XW'(in_rad[l]);
					res_in[l] = '0;
				end
			end
			assign vld_in = in_valid;
			assign sgn_in = in_sign;
		end else begin : g_src
			assign rem_in = rem_s[k];
			assign res_in = res_s[k];
			assign vld_in = vld_s[k];
			assign sgn_in = sgn_s[k];
		end

		always_comb begin
			for (int l = 0; l < NUM_LANES; l++) begin
				trial[l] = res_in[l] + BIT;
				if (rem_in[l] >= trial[l]) begin
					rem_next[l] = rem_in[l] - trial[l];
					res_next[l] = (res_in[l] >> 1) + BIT;
				end else begin
					rem_next[l] = rem_in[l];
					res_next[l] = res_in[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_next;
				res_s[k+1] <= res_next;
				sgn_s[k+1] <= sgn_in;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			out_root[l] = res_s[N][l][N-1:0];
		end
	end

	assign out_valid = vld_s[N];
	assign out_sign  = sgn_s[N];

endmodule

// ----- design/rmq_out.sv -----
`timescale 1ns / 1ps

module rmq_out import rmq_pkg::*; #(
	parameter int N = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [N-1:0]          in_root [NUM_LANES],
	input  sign_t                 in_sign,
	output logic                  en,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int HW = (N > ELEM_W) ? N : ELEM_W;

	logic [HW-1:0]   half [NUM_LANES];
	logic [QW_W-1:0] mag  [NUM_LANES];
	result_t         res;
	logic            push;
	logic            out_ready;

	logic            out_valid_q;
	result_t         out_q;
	logic            skid_valid_q;
	result_t         skid_q;

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			half[l] = HW'(in_root[l] >> 1);
			if (half[l] > HW'(MAG_MAX)) begin
				mag[l] = MAG_MAX;
			end else begin
				mag[l] = half[l][QW_W-1:0];
			end
		end
		res.q_w = mag[LANE_W];
		res.q_x = in_sign.neg_x ? -ELEM_W'(mag[LANE_X]) : ELEM_W'(mag[LANE_X]);
		res.q_y = in_sign.neg_y ? -ELEM_W'(mag[LANE_Y]) : ELEM_W'(mag[LANE_Y]);
		res.q_z = in_sign.neg_z ? -ELEM_W'(mag[LANE_Z]) : ELEM_W'(mag[LANE_Z]);
	end

	// pipe moves only while the skid word is free
	assign en        = !skid_valid_q;
	assign push      = en && in_valid;
	assign out_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

endmodule

// ----- design/rotation_matrix_to_quaternion_top.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Bits  Contents
// s_axis   in   144   right_x, right_y, right_z, up_x, up_y, up_z, at_x, at_y, at_z
// m_axis   out  64    q_w (15), q_x, q_y, q_z, one pad bit
//
// One matrix word per cycle while the skid word is free; a word taken passes
// N + 2 register stages on its way to m_axis, with N = ceil(RW / 2) digit steps of
// the root pipe and RW = max(FRACTION_BITS, 17) + 1 + FRACTION_BITS
// (32 at the default). The four-lane root pipe yields one result digit per stage.
// Reset clears the valid bits only. A stall fills the skid word, then freezes the
// whole pipe; s_tready is a register output and does not depend on m_tready.

module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
	parameter int FRACTION_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// right_x, right_y, right_z, up_x, up_y, up_z, at_x, at_y, at_z (16 bits each)
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// q_w [14:0], q_x [30:15], q_y [46:31], q_z [62:47], zero [63]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int RW = ((FRACTION_BITS > 17) ? FRACTION_BITS : 17) + 1 + FRACTION_BITS;
	localparam int N  = (RW + 1) / 2;

	logic          en;
	logic          front_valid;
	logic [RW-1:0] front_rad [NUM_LANES];
	sign_t         front_sign;
	logic          root_valid;
	logic [N-1:0]  root [NUM_LANES];
	sign_t         root_sign;

	assign s_tready = en;

	rmq_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_m     (matrix_t'(s_tdata)),
		.out_valid(front_valid),
		.out_rad  (front_rad),
		.out_sign (front_sign)
	);

	rmq_root_pipe #(
		.RW(RW)
	) u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (front_valid),
		.in_rad   (front_rad),
		.in_sign  (front_sign),
		.out_valid(root_valid),
		.out_root (root),
		.out_sign (root_sign)
	);

	rmq_out #(
		.N(N)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(root_valid),
		.in_root (root),
		.in_sign (root_sign),
		.en      (en),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
